>>> design/ocb3_pkg.sv
// Shared types, constants and AES round functions for the OCB3 short-message encryptor.
// No dependencies.
package ocb3_pkg;

  localparam int BlkW = 128;
  // pipeline depth of one AES pass: input whitening plus ten round cells
  localparam int AesLat = 11;

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_LSTAR_HIGH = 2'd2,
    REG_LSTAR_LOW  = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] RconFirst = 8'h01;
  localparam logic [7:0] RconLast  = 8'h36;
  localparam logic [7:0] RedPoly   = 8'h1b;
  localparam logic [7:0] DblPoly   = 8'd135;
  localparam logic [7:0] PadByte   = 8'h80;

  localparam logic [7:0] Sbox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // side data riding along the first AES pass
  typedef struct packed {
    logic [BlkW-1:0] plain;
    logic [4:0]      pbytes;
    logic [5:0]      bottom;
    logic            err;
    logic            assoc_used;
  } p1_side_t;

  // side data riding along the message AES pass
  typedef struct packed {
    logic [BlkW-1:0] off;
    logic [BlkW-1:0] plain;
    logic [4:0]      pbytes;
    logic [BlkW-1:0] hash;
    logic            err;
    logic            assoc_used;
  } p2_side_t;

  // side data riding along the tag AES pass
  typedef struct packed {
    logic [BlkW-1:0] cipher;
    logic [BlkW-1:0] hash;
    logic            err;
    logic            assoc_used;
  } p3_side_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? RedPoly : 8'h00);
  endfunction

  function automatic logic [BlkW-1:0] gf_double(input logic [BlkW-1:0] a);
    gf_double = {a[BlkW-2:0], 1'b0} ^ {{(BlkW-8){1'b0}}, (a[BlkW-1] ? DblPoly : 8'h00)};
  endfunction

  // next round key from the current one
  function automatic logic [BlkW-1:0] key_next(input logic [BlkW-1:0] rk,
                                               input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    tmp = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
  function automatic logic [BlkW-1:0] aes_round(input logic [BlkW-1:0] s,
                                                input logic [BlkW-1:0] rk,
                                                input logic last);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [BlkW-1:0] r;
    for (int i = 0; i < 16; i++) begin
      t[(i % 4) + 4 * (((i / 4) + 4 - (i % 4)) % 4)] = Sbox[s[127 - 8 * i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      m[4 * c]     = last ? a0 : (a0 ^ x ^ xtime(a0 ^ a1));
      m[4 * c + 1] = last ? a1 : (a1 ^ x ^ xtime(a1 ^ a2));
      m[4 * c + 2] = last ? a2 : (a2 ^ x ^ xtime(a2 ^ a3));
      m[4 * c + 3] = last ? a3 : (a3 ^ x ^ xtime(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = m[i];
    end
    aes_round = r ^ rk;
  endfunction

  // keep the first n bytes
  function automatic logic [BlkW-1:0] prefix(input logic [BlkW-1:0] a, input logic [4:0] n);
    prefix = a & ~({BlkW{1'b1}} >> {n, 3'b000});
  endfunction

  // first n bytes followed by 10* padding
  function automatic logic [BlkW-1:0] padded(input logic [BlkW-1:0] a, input logic [4:0] n);
    padded = prefix(a, n) ^ ({{(BlkW-8){1'b0}}, PadByte} << (8'd120 - {n, 3'b000}));
  endfunction

endpackage

>>> design/ocb3_round_cell.sv
// One AES-128 round cell: a round on the state plus the matching key expansion step.
// Depends on ocb3_pkg.
module ocb3_round_cell import ocb3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [BlkW-1:0] state_i,
  input  logic [BlkW-1:0] rkey_i,
  input  logic [7:0]      rcon_i,
  output logic            valid_o,
  output logic [BlkW-1:0] state_o,
  output logic [BlkW-1:0] rkey_o,
  output logic [7:0]      rcon_o
);

  logic            valid_q;
  logic [BlkW-1:0] state_q, state_d, rkey_q, rkey_d;
  logic [7:0]      rcon_q, rcon_d;

  always_comb begin
    rkey_d  = key_next(rkey_i, rcon_i);
    state_d = aes_round(state_i, rkey_d, rcon_i == RconLast);
    rcon_d  = xtime(rcon_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    rcon_q  <= rcon_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign rkey_o  = rkey_q;
  assign rcon_o  = rcon_q;

endmodule

>>> design/ocb3_aes_pipe.sv
// AES-128 encryption pipe: whitening register followed by a chain of ten round cells.
// Depends on ocb3_pkg and ocb3_round_cell.
module ocb3_aes_pipe import ocb3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [BlkW-1:0] block_i,
  input  logic [BlkW-1:0] key_i,
  output logic            valid_o,
  output logic [BlkW-1:0] block_o
);

  localparam int NumRounds = 10;

  logic            v   [NumRounds+1];
  logic [BlkW-1:0] st  [NumRounds+1];
  logic [BlkW-1:0] rk  [NumRounds+1];
  logic [7:0]      rc  [NumRounds+1];

  logic            v0_q;
  logic [BlkW-1:0] st0_q, rk0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q <= block_i ^ key_i;
    rk0_q <= key_i;
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;
  assign rk[0] = rk0_q;
  assign rc[0] = RconFirst;

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    ocb3_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[g]),
      .state_i (st[g]),
      .rkey_i  (rk[g]),
      .rcon_i  (rc[g]),
      .valid_o (v[g+1]),
      .state_o (st[g+1]),
      .rkey_o  (rk[g+1]),
      .rcon_o  (rc[g+1])
    );
  end

  assign valid_o = v[NumRounds];
  assign block_o = st[NumRounds];

endmodule

>>> design/ocb3_short_message_encrypt.sv
// Top level: OCB3 encryption with AES-128 for one-block messages and associated data.
// Depends on ocb3_pkg and ocb3_aes_pipe.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  item in   | start, busy (always low)     | nonce_*, plain_*, assoc_* and byte counts
//  config    | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//  result    | result_valid_o (strobe)      | cipher_*, tag_*, length_error_o
//
// One item may enter every cycle.
// Each item runs through three chained AES passes of 11 stages (nonce and associated data in
// parallel, then message, then tag) plus an offset stage and the output register.
// Reset clears the valid bits of every stage and the key and L-star registers.
// The result strobe lasts one cycle; the receiver has no way to stall it.
module ocb3_short_message_encrypt import ocb3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic [55:0] nonce_high_i,
  input  logic [63:0] nonce_low_i,
  input  logic [3:0]  nonce_bytes_i,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic [4:0]  plain_bytes_i,
  input  logic [63:0] assoc_high_i,
  input  logic [63:0] assoc_low_i,
  input  logic [4:0]  assoc_bytes_i,
  output logic        result_valid_o,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  output logic [63:0] tag_high_o,
  output logic [63:0] tag_low_o,
  output logic        length_error_o
);

  localparam int Latency = 3 * AesLat + 2;

  // config registers
  logic [63:0] key_hi_q, key_lo_q, ls_hi_q, ls_lo_q;
  logic [BlkW-1:0] key, lstar, ldollar, lzero;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      ls_hi_q  <= '0;
      ls_lo_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_HIGH:   key_hi_q <= cfg_data_i;
        REG_KEY_LOW:    key_lo_q <= cfg_data_i;
        REG_LSTAR_HIGH: ls_hi_q  <= cfg_data_i;
        REG_LSTAR_LOW:  ls_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key     = {key_hi_q, key_lo_q};
  assign lstar   = {ls_hi_q, ls_lo_q};
  assign ldollar = gf_double(lstar);
  assign lzero   = gf_double(ldollar);

  // ---- entry: nonce block and hashed associated-data input
  logic            accept;
  logic [BlkW-1:0] nonce_full, nonce_mask, nonce_blk, nonce_in, assoc_blk, assoc_in;
  logic [BlkW-1:0] plain_blk;
  p1_side_t        p1_in;

  assign accept = start && !busy;

  always_comb begin
    nonce_full = {8'h00, nonce_high_i, nonce_low_i};
    nonce_mask = ~({BlkW{1'b1}} << {nonce_bytes_i, 3'b000});
    // nonce bytes, then a single 1 bit just above them
    nonce_blk  = (nonce_full & nonce_mask) | ({{(BlkW-1){1'b0}}, 1'b1} << {nonce_bytes_i, 3'b000});
    nonce_in   = {nonce_blk[BlkW-1:6], 6'b000000};
    assoc_blk  = {assoc_high_i, assoc_low_i};
    assoc_in   = (assoc_bytes_i == 5'd16) ? (assoc_blk ^ lzero)
                                          : (padded(assoc_blk, assoc_bytes_i) ^ lstar);
    plain_blk  = {plain_high_i, plain_low_i};
    p1_in.plain      = plain_blk;
    p1_in.pbytes     = plain_bytes_i;
    p1_in.bottom     = nonce_blk[5:0];
    p1_in.err        = (plain_bytes_i > 5'd16) || (assoc_bytes_i > 5'd16);
    p1_in.assoc_used = (assoc_bytes_i != 5'd0);
  end

  logic            ktop_valid, hash_valid;
  logic [BlkW-1:0] ktop, hash;

  ocb3_aes_pipe u_aes_nonce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .block_i (nonce_in),
    .key_i   (key),
    .valid_o (ktop_valid),
    .block_o (ktop)
  );

  ocb3_aes_pipe u_aes_assoc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .block_i (assoc_in),
    .key_i   (key),
    .valid_o (hash_valid),
    .block_o (hash)
  );

  p1_side_t p1_q [AesLat];
  always_ff @(posedge clk_i) begin
    p1_q[0] <= p1_in;
    for (int i = 1; i < AesLat; i++) p1_q[i] <= p1_q[i-1];
  end

  // ---- offset stage: stretch shift, then fold in L0 for a full block or L-star for a partial one
  logic [63:0]     stretch;
  logic [191:0]    shifted;
  logic [BlkW-1:0] off_d;
  logic            xv_q;
  p2_side_t        x_q, x_d;

  always_comb begin
    stretch = ktop[127:64] ^ ktop[119:56];
    shifted = {ktop, stretch} << p1_q[AesLat-1].bottom;
    off_d   = shifted[191:64];
    if (p1_q[AesLat-1].pbytes == 5'd16) begin
      off_d = off_d ^ lzero;
    end else if (p1_q[AesLat-1].pbytes != 5'd0) begin
      off_d = off_d ^ lstar;
    end
    x_d.off        = off_d;
    x_d.plain      = p1_q[AesLat-1].plain;
    x_d.pbytes     = p1_q[AesLat-1].pbytes;
    x_d.hash       = hash;
    x_d.err        = p1_q[AesLat-1].err;
    x_d.assoc_used = p1_q[AesLat-1].assoc_used;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= 1'b0;
    end else begin
      xv_q <= ktop_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // ---- message pass: full block is ECB under the offset, partial block is a pad
  logic            msg_valid;
  logic [BlkW-1:0] msg_in, msg_out;

  assign msg_in = (x_q.pbytes == 5'd16) ? (x_q.plain ^ x_q.off) : x_q.off;

  ocb3_aes_pipe u_aes_msg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (xv_q),
    .block_i (msg_in),
    .key_i   (key),
    .valid_o (msg_valid),
    .block_o (msg_out)
  );

  p2_side_t p2_q [AesLat];
  always_ff @(posedge clk_i) begin
    p2_q[0] <= x_q;
    for (int i = 1; i < AesLat; i++) p2_q[i] <= p2_q[i-1];
  end

  // ---- tag pass: checksum ^ offset ^ L$
  p2_side_t        m2;
  logic [BlkW-1:0] cipher_d, chk, tag_in;
  p3_side_t        p3_in;

  always_comb begin
    m2 = p2_q[AesLat-1];
    if (m2.pbytes == 5'd16) begin
      cipher_d = msg_out ^ m2.off;
      chk      = m2.plain;
    end else if (m2.pbytes != 5'd0) begin
      cipher_d = prefix(msg_out ^ m2.plain, m2.pbytes);
      chk      = padded(m2.plain, m2.pbytes);
    end else begin
      cipher_d = '0;
      chk      = '0;
    end
    tag_in           = chk ^ m2.off ^ ldollar;
    p3_in.cipher     = cipher_d;
    p3_in.hash       = m2.hash;
    p3_in.err        = m2.err;
    p3_in.assoc_used = m2.assoc_used;
  end

  logic            tag_valid;
  logic [BlkW-1:0] tag_out;

  ocb3_aes_pipe u_aes_tag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (msg_valid),
    .block_i (tag_in),
    .key_i   (key),
    .valid_o (tag_valid),
    .block_o (tag_out)
  );

  p3_side_t p3_q [AesLat];
  always_ff @(posedge clk_i) begin
    p3_q[0] <= p3_in;
    for (int i = 1; i < AesLat; i++) p3_q[i] <= p3_q[i-1];
  end

  // ---- output register
  p3_side_t        f;
  logic            rv_q;
  logic [BlkW-1:0] cip_q, cip_d, tag_q, tag_d;
  logic            err_q;

  always_comb begin
    f     = p3_q[AesLat-1];
    tag_d = tag_out ^ (f.assoc_used ? f.hash : '0);
    cip_d = f.cipher;
    if (f.err) begin
      tag_d = '0;
      cip_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= tag_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cip_q <= cip_d;
    tag_q <= tag_d;
    err_q <= f.err;
  end

  assign result_valid_o = rv_q;
  assign cipher_high_o  = cip_q[127:64];
  assign cipher_low_o   = cip_q[63:0];
  assign tag_high_o     = tag_q[127:64];
  assign tag_low_o      = tag_q[63:0];
  assign length_error_o = err_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency result_valid_o)
    else $error("item did not produce a result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, Latency))
    else $error("result without a matching item");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && length_error_o) |->
      (cipher_high_o == '0 && cipher_low_o == '0 && tag_high_o == '0 && tag_low_o == '0))
    else $error("length error result carries data");

  a_passes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ktop_valid == hash_valid)
    else $error("nonce and associated-data passes out of step");
`endif

endmodule
